@@ sv/wsdf_pkg.sv @@
// shared types and constants of the websocket frame deframer
`timescale 1ns / 1ps
package wsdf_pkg;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_DATA
	} phase_t;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'ha;

	localparam logic [1:0] KIND_MSG   = 2'd0;
	localparam logic [1:0] KIND_PING  = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_ERR   = 2'd3;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_RSV       = 4'd1;
	localparam logic [3:0] ERR_MASK      = 4'd2;
	localparam logic [3:0] ERR_LEN_MSB   = 4'd3;
	localparam logic [3:0] ERR_TOO_BIG   = 4'd4;
	localparam logic [3:0] ERR_CONTROL   = 4'd5;
	localparam logic [3:0] ERR_CLOSE_TR  = 4'd6;
	localparam logic [3:0] ERR_TEXT      = 4'd7;
	localparam logic [3:0] ERR_INTERRUPT = 4'd8;
	localparam logic [3:0] ERR_ORPHAN    = 4'd9;
	localparam logic [3:0] ERR_FRAG_BIG  = 4'd10;
	localparam logic [3:0] ERR_BAD_OP    = 4'd11;

	localparam logic [0:0] REG_ROLE = 1'b0;
	localparam logic [0:0] REG_MAX  = 1'b1;

	localparam logic [31:0] MAX_SIZE_RESET = 32'd65536;
	localparam logic [6:0]  LEN16_CODE     = 7'd126;
	localparam logic [6:0]  LEN64_CODE     = 7'd127;
	localparam logic [6:0]  CTRL_MAX_LEN   = 7'd125;

	// queue between parser and output stage
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic       has_data;
		logic       last;
		logic [3:0] error_code;
	} result_t;

endpackage

@@ sv/wsdf_parser.sv @@
// front part: header decoding, checks and payload unmasking
`timescale 1ns / 1ps
module wsdf_parser import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_role_q,
	input  logic [31:0] cfg_max_q,
	input  logic        take,
	input  logic [7:0]  stream_byte,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  hdr0_q, hdr0_d;
	logic [63:0] len_q, len_d;
	logic [3:0]  ext_q, ext_d;
	logic [31:0] key_q, key_d;
	logic [63:0] left_q, left_d;
	logic [1:0]  mpos_q, mpos_d;
	logic        fopen_q, fopen_d;
	logic [31:0] ftot_q, ftot_d;
	logic        halt_q, halt_d;
	logic        masked_q, masked_d;

	logic [3:0]  op;
	logic        fin;
	logic [63:0] len_new;
	logic [64:0] frag_sum;
	logic [7:0]  key_byte;
	logic        lchk_go, lchk_fail, hend_go;
	logic [3:0]  lchk_code;

	assign op  = hdr0_q[3:0];
	assign fin = hdr0_q[7];

	always_comb begin
		unique case (mpos_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result of one byte
	always_comb begin
		phase_d = phase_q; hdr0_d = hdr0_q; len_d = len_q; ext_d = ext_q;
		key_d = key_q; left_d = left_q; mpos_d = mpos_q; fopen_d = fopen_q;
		ftot_d = ftot_q; halt_d = halt_q; masked_d = masked_q;
		res_valid = 1'b0;
		res = '{kind: KIND_MSG, payload_byte: 8'd0, has_data: 1'b0, last: 1'b0,
			error_code: ERR_NONE};
		lchk_go = 1'b0; hend_go = 1'b0;
		lchk_fail = 1'b0; lchk_code = ERR_NONE;
		frag_sum = 65'd0;
		len_new = {len_q[55:0], stream_byte};
		if (take && !halt_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					hdr0_d = stream_byte;
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = stream_byte[7];
					len_d = 64'd0;
					if (hdr0_q[6:4] != 3'd0) begin
						res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_RSV;
						halt_d = 1'b1;
					end else if (stream_byte[7] != cfg_role_q) begin
						res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_MASK;
						halt_d = 1'b1;
					end else if (stream_byte[6:0] == LEN16_CODE) begin
						ext_d = 4'd2; phase_d = PH_EXT;
					end else if (stream_byte[6:0] == LEN64_CODE) begin
						ext_d = 4'd8; phase_d = PH_EXT;
					end else begin
						len_d = {57'd0, stream_byte[6:0]};
						lchk_go = 1'b1;
					end
				end
				PH_EXT: begin
					len_d = len_new;
					ext_d = ext_q - 4'd1;
					if (ext_d == 4'd0) begin
						if (len_new[63]) begin
							res_valid = 1'b1; res.kind = KIND_ERR;
							res.error_code = ERR_LEN_MSB; halt_d = 1'b1;
						end else begin
							lchk_go = 1'b1;
						end
					end
				end
				PH_KEY: begin
					key_d = {key_q[23:0], stream_byte};
					mpos_d = mpos_q + 2'd1;
					if (mpos_d == 2'd0) hend_go = 1'b1;
				end
				default: begin
					mpos_d = mpos_q + 2'd1;
					left_d = left_q - 64'd1;
					if (left_d == 64'd0) phase_d = PH_HDR0;
					res.payload_byte = stream_byte ^ key_byte;
					res.has_data = 1'b1;
					if (op == OP_PING) begin
						res_valid = 1'b1; res.kind = KIND_PING;
						res.last = (left_d == 64'd0);
					end else if (op == OP_CLOSE) begin
						res_valid = 1'b1; res.kind = KIND_CLOSE;
						res.last = (left_d == 64'd0);
						if (left_d == 64'd0) halt_d = 1'b1;
					end else if (op != OP_PONG) begin
						res_valid = 1'b1; res.kind = KIND_MSG;
						res.last = (left_d == 64'd0) && fin;
					end
				end
			endcase

			// length complete: size and control checks
			if (lchk_go) begin
				if (len_d > {32'd0, cfg_max_q}) begin
					lchk_fail = 1'b1; lchk_code = ERR_TOO_BIG;
				end else if (op[3] && (!fin || len_d > {57'd0, CTRL_MAX_LEN})) begin
					lchk_fail = 1'b1; lchk_code = ERR_CONTROL;
				end
				if (lchk_fail) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = lchk_code;
					halt_d = 1'b1;
				end else begin
					key_d = 32'd0; mpos_d = 2'd0;
					if (masked_d) phase_d = PH_KEY;
					else hend_go = 1'b1;
				end
			end

			// header end: opcode and fragment rules
			frag_sum = {33'd0, ftot_q} + {1'b0, len_d};
			if (hend_go) begin
				priority if (op == OP_CLOSE && len_d == 64'd1) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_CLOSE_TR;
					halt_d = 1'b1;
				end else if (op == OP_TEXT) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_TEXT;
					halt_d = 1'b1;
				end else if (op == OP_BIN && fopen_q) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_INTERRUPT;
					halt_d = 1'b1;
				end else if (op == OP_CONT && !fopen_q) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_ORPHAN;
					halt_d = 1'b1;
				end else if (op == OP_CONT && frag_sum > {33'd0, cfg_max_q}) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_FRAG_BIG;
					halt_d = 1'b1;
				end else if (op != OP_CLOSE && op != OP_PING && op != OP_PONG
					&& op != OP_BIN && op != OP_CONT) begin
					res_valid = 1'b1; res.kind = KIND_ERR; res.error_code = ERR_BAD_OP;
					halt_d = 1'b1;
				end else begin
					if (op == OP_BIN && !fin) begin
						fopen_d = 1'b1; ftot_d = len_d[31:0];
					end else if (op == OP_CONT) begin
						if (fin) begin
							fopen_d = 1'b0; ftot_d = 32'd0;
						end else begin
							ftot_d = frag_sum[31:0];
						end
					end
					left_d = len_d;
					mpos_d = 2'd0;
					if (len_d != 64'd0) begin
						phase_d = PH_DATA;
					end else begin
						phase_d = PH_HDR0;
						res.last = 1'b1;
						if (op == OP_PING) begin
							res_valid = 1'b1; res.kind = KIND_PING;
						end else if (op == OP_CLOSE) begin
							res_valid = 1'b1; res.kind = KIND_CLOSE; halt_d = 1'b1;
						end else if (op != OP_PONG && fin) begin
							res_valid = 1'b1; res.kind = KIND_MSG;
						end
					end
				end
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0; hdr0_q <= 8'd0; len_q <= 64'd0; ext_q <= 4'd0;
			key_q <= 32'd0; left_q <= 64'd0; mpos_q <= 2'd0; fopen_q <= 1'b0;
			ftot_q <= 32'd0; halt_q <= 1'b0; masked_q <= 1'b0;
		end else begin
			phase_q <= phase_d; hdr0_q <= hdr0_d; len_q <= len_d; ext_q <= ext_d;
			key_q <= key_d; left_q <= left_d; mpos_q <= mpos_d; fopen_q <= fopen_d;
			ftot_q <= ftot_d; halt_q <= halt_d; masked_q <= masked_d;
		end
	end

endmodule

@@ sv/wsdf_queue.sv @@
// back part: result queue in front of the consumer
`timescale 1ns / 1ps
module wsdf_queue import wsdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  result_t wdata,
	input  logic    rd,
	output result_t rdata,
	output logic    empty,
	output logic    room2
);

	result_t      mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	// space for this transfer and one more still in the result register
	assign room2 = (cnt_q <= (QAW+1)'(QDEPTH - 2));
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + QAW'(1);
			if (rd) rp_q <= rp_q + QAW'(1);
			cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

endmodule

@@ sv/websocket_frame_deframer.sv @@
// top level of the websocket frame deframer
`timescale 1ns / 1ps
// Receive-side WebSocket frame parser: one stream byte is taken per cycle
// whenever full is low, and each byte gives at most one result (payload byte,
// empty-payload marker or error). The result passes one register and is then
// written into a four-entry queue, whose head drives the result ports.
// Sustained rate is one byte per cycle while full is low; full rises only when
// three or more results wait in the queue.
// After an error or the end of a close frame all input is dropped until reset.
module websocket_frame_deframer import wsdf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  stream_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  payload_byte,
	output logic        has_data,
	output logic        last,
	output logic [3:0]  error_code
);

	logic        role_q;
	logic [31:0] max_q;
	logic        res_valid;
	result_t     res, res_s1, head;
	logic        valid_s1, room2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q <= 1'b0; max_q <= MAX_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROLE: role_q <= cfg_data[0];
				default:  max_q  <= cfg_data;
			endcase
		end
	end

	assign full = !room2;

	wsdf_parser u_parser (
		.clk(clk), .arst_n(arst_n), .cfg_role_q(role_q), .cfg_max_q(max_q),
		.take(push && !full), .stream_byte(stream_byte),
		.res_valid(res_valid), .res(res)
	);

	// result register between parser and queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= res_valid;
	end
	always_ff @(posedge clk) res_s1 <= res;

	wsdf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(valid_s1), .wdata(res_s1),
		.rd(pop && !empty), .rdata(head), .empty(empty), .room2(room2)
	);

	assign kind = head.kind;
	assign payload_byte = head.payload_byte;
	assign has_data = head.has_data;
	assign last = head.last;
	assign error_code = head.error_code;

endmodule
